// ----- hw/rtl/swcs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swcs_pkg: shared types and constants of the stop-and-wait CAN sender
// Frame layout, history entry layout, result word layout, action codes
// and the sizing of the wait queue and the history ring.
// ----------------------------------------------------------------------------
package swcs_pkg;

	localparam int QUEUE_DEPTH   = 16;
	localparam int HISTORY_DEPTH = 16;

	localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCW = $clog2(QUEUE_DEPTH + 1);
	localparam int HAW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int HCW = $clog2(HISTORY_DEPTH + 1);

	localparam logic [15:0] ACK_TIMEOUT_RST = 16'd10;

	localparam logic [1:0] ACT_SEND = 2'd0;
	localparam logic [1:0] ACT_TICK = 2'd1;
	localparam logic [1:0] ACT_RESP = 2'd2;

	typedef struct packed {
		logic [63:0] payload;
		logic [3:0]  length;
		logic [7:0]  command;
	} frame_t;

	typedef struct packed {
		logic [31:0] sent;
		frame_t      frame;
	} hist_entry_t;

	typedef struct packed {
		logic [31:0] ack_delay;
		frame_t      tx;
		logic        dropped;
		logic        matched;
		logic        tx_valid;
	} result_t;

	// byte mask over the first min(len, 8) data bytes
	function automatic logic [63:0] byte_mask(input logic [3:0] len);
		logic [63:0] m;
		m = '0;
		for (int i = 0; i < 8; i++) begin
			if (len > 4'(i)) begin
				m[8*i +: 8] = 8'hFF;
			end
		end
		return m;
	endfunction

endpackage

// ----- hw/rtl/stop_and_wait_can_sender.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stop_and_wait_can_sender: stop-and-wait CAN frame sender with ack tracking
// Queues send requests behind an unacknowledged frame, keeps a history ring
// of sent frames and matches responses against it newest first.
// ----------------------------------------------------------------------------
// Usage
//  s_axis: one word per event; tuser is the action (send, tick, response).
//  m_axis: exactly one result word per input word, in order.
//  cfg:    writes ack_timeout; always ready, write only while idle.
// Timing
//  The sequencer holds one word at a time; s_axis_tready is low while it
//  works. A send or an unused action passes through decide and finish, a
//  tick through decide, release and finish. A response walks the history
//  ring through one compare unit, one entry per cycle behind a registered
//  memory read, until a match or the end of the ring.
//  The result sits in an output register, so the next word is taken while
//  the previous result waits; a stalled receiver holds only the finish step.
// Reset
//  arst_n clears the queue, history, time and result; ack_timeout returns
//  to 10. No clearing pass is needed.
// ----------------------------------------------------------------------------
module stop_and_wait_can_sender (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// [31:0] now_ticks, [39:32] frame_command, [43:40] frame_length,
	// [107:44] frame_payload, [111:108] zero
	input  logic [111:0] s_axis_tdata,
	// [1:0] action
	input  logic [1:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// [7:0] tx_command, [11:8] tx_length, [75:12] tx_payload,
	// [107:76] ack_delay, [111:108] zero
	output logic [111:0] m_axis_tdata,
	// [0] tx_valid, [1] matched, [2] dropped
	output logic [2:0]   m_axis_tuser,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [15:0]  cfg_data
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_SCAN,
		ST_RELEASE,
		ST_FINISH
	} state_t;

	state_t state_q;

	logic [15:0]             timeout_q;
	logic [31:0]             cur_q;
	logic [1:0]              act_q;
	logic [31:0]             now_q;
	swcs_pkg::frame_t        frm_q;

	swcs_pkg::frame_t        wait_mem [swcs_pkg::QUEUE_DEPTH];
	swcs_pkg::frame_t        q_rd_q;
	logic [swcs_pkg::QAW-1:0] wait_head_q;
	logic [swcs_pkg::QCW-1:0] wait_count_q;

	swcs_pkg::hist_entry_t   hist_mem [swcs_pkg::HISTORY_DEPTH];
	swcs_pkg::hist_entry_t   hist_rd_s1;
	logic [swcs_pkg::HAW-1:0] hist_slot_s1;
	logic                    hist_pend_s1;
	logic [swcs_pkg::HAW-1:0] scan_slot_q;
	logic [swcs_pkg::HCW-1:0] scan_left_q;
	logic [swcs_pkg::HAW-1:0] hist_next_q;
	logic [swcs_pkg::HCW-1:0] hist_count_q;
	logic [swcs_pkg::HISTORY_DEPTH-1:0] acked_q;
	logic [31:0]             newest_time_q;

	swcs_pkg::result_t       res_q;
	swcs_pkg::result_t       out_q;
	logic                    m_valid_q;

	logic [swcs_pkg::HAW-1:0] newest_slot;
	logic [swcs_pkg::HAW-1:0] scan_prev;
	logic [swcs_pkg::HAW-1:0] next_wrap;
	logic [31:0]             age;
	logic                    newest_clear;
	logic                    cmp_hit;
	logic [swcs_pkg::QCW:0]  tail_sum;
	logic [swcs_pkg::QAW-1:0] tail;
	logic [swcs_pkg::QAW-1:0] head_wrap;
	logic                    send_now;
	logic                    enq;
	logic                    rel_now;
	logic                    tx_go;
	swcs_pkg::frame_t        tx_frame;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tuser  = {out_q.dropped, out_q.matched, out_q.tx_valid};
	assign m_axis_tdata  = {4'b0, out_q.ack_delay, out_q.tx.payload,
		out_q.tx.length, out_q.tx.command};

	always_comb begin
		newest_slot = (hist_next_q == '0) ? swcs_pkg::HAW'(swcs_pkg::HISTORY_DEPTH - 1)
			: hist_next_q - 1'b1;
		scan_prev   = (scan_slot_q == '0) ? swcs_pkg::HAW'(swcs_pkg::HISTORY_DEPTH - 1)
			: scan_slot_q - 1'b1;
		next_wrap   = (hist_next_q == swcs_pkg::HAW'(swcs_pkg::HISTORY_DEPTH - 1)) ? '0
			: hist_next_q + 1'b1;
		head_wrap   = (wait_head_q == swcs_pkg::QAW'(swcs_pkg::QUEUE_DEPTH - 1)) ? '0
			: wait_head_q + 1'b1;
		age          = cur_q - newest_time_q;
		newest_clear = (hist_count_q == '0) || acked_q[newest_slot]
			|| (age >= 32'(timeout_q));
		// the single compare unit: one history entry against the response
		cmp_hit = hist_pend_s1 && !acked_q[hist_slot_s1]
			&& (hist_rd_s1.frame.command == frm_q.command)
			&& (hist_rd_s1.frame.length == frm_q.length)
			&& (((hist_rd_s1.frame.payload ^ frm_q.payload)
				& swcs_pkg::byte_mask(frm_q.length)) == 64'd0);
		tail_sum = (swcs_pkg::QCW + 1)'(wait_head_q) + (swcs_pkg::QCW + 1)'(wait_count_q);
		tail     = (tail_sum >= (swcs_pkg::QCW + 1)'(swcs_pkg::QUEUE_DEPTH))
			? swcs_pkg::QAW'(tail_sum - (swcs_pkg::QCW + 1)'(swcs_pkg::QUEUE_DEPTH))
			: swcs_pkg::QAW'(tail_sum);
		send_now = (state_q == ST_DECIDE) && (act_q == swcs_pkg::ACT_SEND)
			&& (wait_count_q == '0) && newest_clear;
		enq      = (state_q == ST_DECIDE) && (act_q == swcs_pkg::ACT_SEND) && !send_now
			&& (wait_count_q < swcs_pkg::QCW'(swcs_pkg::QUEUE_DEPTH));
		rel_now  = (state_q == ST_RELEASE) && (wait_count_q != '0) && newest_clear;
		tx_go    = send_now || rel_now;
		tx_frame = send_now ? frm_q : q_rd_q;
	end

	// wait queue: head word read every cycle, settles long before it is used
	always_ff @(posedge clk) begin
		if (enq) begin
			wait_mem[tail] <= frm_q;
		end
		q_rd_q <= wait_mem[wait_head_q];
	end

	always_ff @(posedge clk) begin
		if (tx_go) begin
			hist_mem[hist_next_q] <= '{sent: cur_q, frame: tx_frame};
		end
		hist_rd_s1   <= hist_mem[scan_slot_q];
		hist_slot_s1 <= scan_slot_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			timeout_q     <= swcs_pkg::ACK_TIMEOUT_RST;
			cur_q         <= '0;
			act_q         <= '0;
			now_q         <= '0;
			frm_q         <= '0;
			wait_head_q   <= '0;
			wait_count_q  <= '0;
			hist_pend_s1  <= 1'b0;
			scan_slot_q   <= '0;
			scan_left_q   <= '0;
			hist_next_q   <= '0;
			hist_count_q  <= '0;
			acked_q       <= '0;
			newest_time_q <= '0;
			res_q         <= '0;
			out_q         <= '0;
			m_valid_q     <= 1'b0;
		end else begin
			if (cfg_valid) begin
				timeout_q <= cfg_data;
			end
			// the finish step owns the result register while it is active
			if (m_valid_q && m_axis_tready && state_q != ST_FINISH) begin
				m_valid_q <= 1'b0;
			end
			if (tx_go) begin
				acked_q[hist_next_q] <= 1'b0;
				hist_next_q          <= next_wrap;
				newest_time_q        <= cur_q;
				if (hist_count_q != swcs_pkg::HCW'(swcs_pkg::HISTORY_DEPTH)) begin
					hist_count_q <= hist_count_q + 1'b1;
				end
				res_q.tx_valid <= 1'b1;
				res_q.tx       <= tx_frame;
			end
			if (enq) begin
				wait_count_q <= wait_count_q + 1'b1;
			end
			if (rel_now) begin
				wait_head_q  <= head_wrap;
				wait_count_q <= wait_count_q - 1'b1;
			end

			case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						act_q         <= s_axis_tuser;
						now_q         <= s_axis_tdata[31:0];
						frm_q.command <= s_axis_tdata[39:32];
						frm_q.length  <= s_axis_tdata[43:40];
						frm_q.payload <= s_axis_tdata[107:44];
						res_q         <= '0;
						state_q       <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					case (act_q)
						swcs_pkg::ACT_SEND: begin
							if (!send_now && !enq) begin
								res_q.dropped <= 1'b1;
							end
							state_q <= ST_FINISH;
						end
						swcs_pkg::ACT_TICK: begin
							cur_q   <= now_q;
							state_q <= ST_RELEASE;
						end
						swcs_pkg::ACT_RESP: begin
							scan_slot_q  <= newest_slot;
							scan_left_q  <= hist_count_q;
							hist_pend_s1 <= 1'b0;
							state_q      <= ST_SCAN;
						end
						default: begin
							state_q <= ST_FINISH;
						end
					endcase
				end
				ST_SCAN: begin
					if (cmp_hit) begin
						acked_q[hist_slot_s1] <= 1'b1;
						res_q.matched         <= 1'b1;
						res_q.ack_delay       <= cur_q - hist_rd_s1.sent;
						state_q               <= ST_RELEASE;
					end else if (scan_left_q == '0 && !hist_pend_s1) begin
						state_q <= ST_FINISH;
					end else begin
						// advance one entry towards the oldest
						hist_pend_s1 <= (scan_left_q != '0);
						if (scan_left_q != '0) begin
							scan_slot_q <= scan_prev;
							scan_left_q <= scan_left_q - 1'b1;
						end
					end
				end
				ST_RELEASE: begin
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (!m_valid_q || m_axis_tready) begin
						out_q     <= res_q;
						m_valid_q <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_wait_bound: assert property (@(posedge clk) disable iff (!arst_n)
		wait_count_q <= swcs_pkg::QCW'(swcs_pkg::QUEUE_DEPTH))
		else $error("wait queue count beyond depth");

	a_hist_bound: assert property (@(posedge clk) disable iff (!arst_n)
		hist_count_q <= swcs_pkg::HCW'(swcs_pkg::HISTORY_DEPTH))
		else $error("history count beyond depth");

	a_ack_set: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && cmp_hit) |=> acked_q[$past(hist_slot_s1)])
		else $error("matched history entry not marked acknowledged");

	a_tx_not_dropped: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[2]))
		else $error("result both transmits and drops a frame");

endmodule
